>>> hw/rtl/dtd_pkg.sv
// Shared types, codes and constants for the decimal text to binary64 converter.
// Used by dtd_fpu and decimal_text_to_double_unit; depends on nothing else.
package dtd_pkg;

  // Default saturation bound on the decimal exponent
  localparam int EXP_BOUND_DEF = 2047;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_UE    = 8'h45;

  // Scaling constants 10.0 and 0.1: significand with hidden bit, biased exponent
  localparam logic [52:0] TEN_MANT   = 53'h14000000000000;
  localparam logic [10:0] TEN_EXP    = 11'd1026;
  localparam logic [52:0] TENTH_MANT = 53'h1999999999999A;
  localparam logic [10:0] TENTH_EXP  = 11'd1019;

  localparam logic [63:0] DBL_POS_ZERO = 64'h0000000000000000;
  localparam logic [63:0] DBL_POS_INF  = 64'h7FF0000000000000;

  // Operations of the shared floating-point unit
  typedef enum logic [1:0] {
    OP_MUL10 = 2'd0,
    OP_MUL01 = 2'd1,
    OP_ADD   = 2'd2
  } fpu_op_t;

  typedef struct packed {
    logic    start;
    fpu_op_t op;
  } fpu_cmd_t;

  typedef struct packed {
    logic done;
    logic busy;
  } fpu_stat_t;

  // 14-bit slice of the constant significand, least significant slice first
  function automatic logic [13:0] const_chunk(input fpu_op_t op, input logic [1:0] idx);
    logic [55:0] m;
    m = (op == OP_MUL01) ? {3'b000, TENTH_MANT} : {3'b000, TEN_MANT};
    return m[{idx, 4'b0000} - {idx, 1'b0} +: 14];
  endfunction

  function automatic logic [10:0] const_exp(input fpu_op_t op);
    return (op == OP_MUL01) ? TENTH_EXP : TEN_EXP;
  endfunction

endpackage

>>> hw/rtl/dtd_fpu.sv
// Iterative binary64 unit: multiply by 10.0 or 0.1, or add a small digit, round to nearest even.
// Operands are never negative and never NaN. Depends on dtd_pkg.
module dtd_fpu (
  input  logic               clk,
  input  logic               rst_n,
  input  dtd_pkg::fpu_cmd_t  cmd,
  input  logic [63:0]        opa,
  input  logic [3:0]         digit,
  output dtd_pkg::fpu_stat_t stat,
  output logic [63:0]        res
);
  import dtd_pkg::*;

  typedef enum logic [5:0] {
    F_IDLE    = 6'b000001,
    F_PRENORM = 6'b000010,
    F_MUL     = 6'b000100,
    F_PACK    = 6'b001000,
    F_NORM    = 6'b010000,
    F_ROUND   = 6'b100000
  } fstate_t;

  fstate_t            fst_r, fst_nxt;
  fpu_op_t            op_r, op_nxt;
  logic [52:0]        ma_r, ma_nxt;
  logic signed [13:0] ea_r, ea_nxt;
  logic [1:0]         cidx_r, cidx_nxt;
  logic [105:0]       prod_r, prod_nxt;
  logic [55:0]        m_r, m_nxt;
  logic               stk_r, stk_nxt;
  logic signed [13:0] e_r, e_nxt;
  logic [63:0]        res_r, res_nxt;
  logic               done_r, done_nxt;

  // Right shift with the shifted-out bits folded into a sticky bit
  function automatic logic [56:0] shr_sticky(input logic [55:0] x, input logic [10:0] amt);
    logic [55:0] mask;
    logic [55:0] y;
    logic        s;
    if (amt >= 11'd56) begin
      y = '0;
      s = |x;
    end else begin
      mask = ~({56{1'b1}} << amt[5:0]);
      y    = x >> amt[5:0];
      s    = |(x & mask);
    end
    return {y, s};
  endfunction

  // Operand decode
  logic [10:0]        a_ef, a_ef_eff;
  logic [52:0]        a_ma;
  logic               a_inf, a_zero;
  logic signed [13:0] diff;
  logic [55:0]        ma_g, d_g;
  logic [56:0]        al_sh;
  logic [55:0]        add_m;
  logic               add_s;
  logic signed [13:0] add_e;

  assign a_ef     = opa[62:52];
  assign a_ef_eff = (a_ef == 11'd0) ? 11'd1 : a_ef;
  assign a_ma     = {a_ef != 11'd0, opa[51:0]};
  assign a_inf    = &a_ef;
  assign a_zero   = (opa[62:0] == 63'd0);
  assign ma_g     = {1'b0, a_ma, 2'b00};
  assign d_g      = 56'(digit) << 50;
  assign diff     = $signed({3'b000, a_ef_eff}) - 14'sd1027;

  // Align the smaller addend to the larger one's frame
  always_comb begin
    if (diff >= 14'sd0) begin
      al_sh = shr_sticky(d_g, diff[10:0]);
      add_m = ma_g + al_sh[56:1];
      add_e = $signed({3'b000, a_ef_eff});
    end else begin
      al_sh = shr_sticky(ma_g, 11'(-diff));
      add_m = d_g + al_sh[56:1];
      add_e = 14'sd1027;
    end
    add_s = al_sh[0];
  end

  // One partial product of the significand and a constant slice
  logic [66:0]  pp;
  logic [5:0]   pp_amt;
  logic [105:0] pp_sh;

  assign pp     = ma_r * const_chunk(op_r, cidx_r);
  assign pp_amt = 6'(cidx_r) * 6'd14;
  assign pp_sh  = 106'(pp) << pp_amt;

  // Rounding and packing
  logic [52:0]        mant;
  logic               rnd_up;
  logic [53:0]        mr;
  logic signed [13:0] e_inc;
  logic [63:0]        rnd;

  assign mant   = m_r[54:2];
  assign rnd_up = m_r[1] & (m_r[0] | stk_r | mant[0]);
  assign mr     = {1'b0, mant} + 54'(rnd_up);
  assign e_inc  = e_r + 14'sd1;

  always_comb begin
    if (m_r == 56'd0) begin
      rnd = DBL_POS_ZERO;
    end else if (mr[53]) begin
      rnd = (e_inc >= 14'sd2047) ? DBL_POS_INF : {1'b0, e_inc[10:0], 52'd0};
    end else if (e_r >= 14'sd2047) begin
      rnd = DBL_POS_INF;
    end else begin
      rnd = {1'b0, (mr[52] ? e_r[10:0] : 11'd0), mr[51:0]};
    end
  end

  // Sequencer
  always_comb begin
    fst_nxt  = fst_r;
    op_nxt   = op_r;
    ma_nxt   = ma_r;
    ea_nxt   = ea_r;
    cidx_nxt = cidx_r;
    prod_nxt = prod_r;
    m_nxt    = m_r;
    stk_nxt  = stk_r;
    e_nxt    = e_r;
    res_nxt  = res_r;
    done_nxt = 1'b0;
    unique case (fst_r)
      F_IDLE: begin
        if (cmd.start) begin
          op_nxt = cmd.op;
          if (a_inf) begin
            res_nxt  = opa;
            done_nxt = 1'b1;
          end else if (cmd.op == OP_ADD) begin
            if (digit == 4'd0) begin
              res_nxt  = opa;
              done_nxt = 1'b1;
            end else begin
              m_nxt   = add_m;
              stk_nxt = add_s;
              e_nxt   = add_e;
              fst_nxt = F_NORM;
            end
          end else if (a_zero) begin
            res_nxt  = opa;
            done_nxt = 1'b1;
          end else begin
            ma_nxt   = a_ma;
            ea_nxt   = $signed({3'b000, a_ef_eff});
            prod_nxt = '0;
            cidx_nxt = 2'd0;
            fst_nxt  = a_ma[52] ? F_MUL : F_PRENORM;
          end
        end
      end
      F_PRENORM: begin
        // subnormal operand: bring the leading one up to the hidden bit
        ma_nxt = ma_r << 1;
        ea_nxt = ea_r - 14'sd1;
        if (ma_r[51]) fst_nxt = F_MUL;
      end
      F_MUL: begin
        prod_nxt = prod_r + pp_sh;
        cidx_nxt = cidx_r + 2'd1;
        if (cidx_r == 2'd3) fst_nxt = F_PACK;
      end
      F_PACK: begin
        m_nxt   = prod_r[105:50];
        stk_nxt = |prod_r[49:0];
        e_nxt   = ea_r + $signed({3'b000, const_exp(op_r)}) - 14'sd1023;
        fst_nxt = F_NORM;
      end
      F_NORM: begin
        if (m_r == 56'd0) begin
          fst_nxt = F_ROUND;
        end else if (m_r[55] || (e_r < 14'sd1)) begin
          m_nxt   = m_r >> 1;
          stk_nxt = stk_r | m_r[0];
          e_nxt   = e_r + 14'sd1;
        end else if (!m_r[54] && (e_r > 14'sd1)) begin
          m_nxt = m_r << 1;
          e_nxt = e_r - 14'sd1;
        end else begin
          fst_nxt = F_ROUND;
        end
      end
      F_ROUND: begin
        res_nxt  = rnd;
        done_nxt = 1'b1;
        fst_nxt  = F_IDLE;
      end
      default: fst_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r  <= F_IDLE;
      done_r <= 1'b0;
    end else begin
      fst_r  <= fst_nxt;
      done_r <= done_nxt;
    end
    op_r   <= op_nxt;
    ma_r   <= ma_nxt;
    ea_r   <= ea_nxt;
    cidx_r <= cidx_nxt;
    prod_r <= prod_nxt;
    m_r    <= m_nxt;
    stk_r  <= stk_nxt;
    e_r    <= e_nxt;
    res_r  <= res_nxt;
  end

  assign stat.done = done_r;
  assign stat.busy = (fst_r != F_IDLE);
  assign res       = res_r;

endmodule

>>> hw/rtl/decimal_text_to_double_unit.sv
// Streaming decimal text to binary64 converter, top level: character parser and sequencer.
// Depends on dtd_pkg and dtd_fpu.
//
// One character per item. Signs, '.', 'e'/'E', exponent digits and skipped characters are each
// taken without the floating-point unit. A mantissa digit takes two passes through the shared
// floating-point unit (multiply by 10.0, then add the digit); the accumulator only ever holds whole
// numbers while digits arrive. A character that ends a number costs one multiply pass per unit of
// the clamped decimal exponent, stopping early once the value is zero or infinite; scaling then
// finishes and the result register is loaded. The one shared unit, with its four-step 53x14-bit
// multiplier, does every multiply and add. After a number ended by any character other than NUL,
// characters are dropped up to the next NUL.
module decimal_text_to_double_unit #(
  parameter int EXP_BOUND = dtd_pkg::EXP_BOUND_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_value_bits
);
  import dtd_pkg::*;

  localparam int EW = $clog2(EXP_BOUND + 1);
  localparam logic [EW-1:0] BOUND = EW'(EXP_BOUND);

  typedef enum logic [5:0] {
    P_SIGN    = 6'b000001,
    P_INT     = 6'b000010,
    P_FRAC    = 6'b000100,
    P_EXPSIGN = 6'b001000,
    P_EXPDIG  = 6'b010000,
    P_SKIP    = 6'b100000
  } phase_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL10 = 5'b00010,
    S_ADD   = 5'b00100,
    S_SCALE = 5'b01000,
    S_EMIT  = 5'b10000
  } seq_t;

  phase_t      phase_r, phase_nxt;
  seq_t        state_r, state_nxt;
  logic [63:0] accum_r, accum_nxt;
  logic [EW-1:0] frac_r, frac_nxt;
  logic [EW-1:0] expd_r, expd_nxt;
  logic        exp_neg_r, exp_neg_nxt;
  logic        is_neg_r, is_neg_nxt;
  logic [EW-1:0] scale_r, scale_nxt;
  logic        scale_neg_r, scale_neg_nxt;
  logic        emit_neg_r, emit_neg_nxt;
  logic [3:0]  digit_r, digit_nxt;
  logic        wait_r, wait_nxt;
  fpu_cmd_t    cmd_r, cmd_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_bits_r, out_bits_nxt;

  fpu_stat_t   fpu_stat;
  logic [63:0] fpu_res;

  dtd_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd_r),
    .opa   (accum_r),
    .digit (digit_r),
    .stat  (fpu_stat),
    .res   (fpu_res)
  );

  // Character classes
  logic          is_dig, is_e, ph_int, ph_expd, acc_done;
  logic [3:0]    dval;
  logic [EW+3:0] expd_v;
  logic [EW:0]   esum;

  assign is_dig   = (in_ch >= CH_ZERO) && (in_ch <= CH_NINE);
  assign dval     = 4'(in_ch - CH_ZERO);
  assign is_e     = (in_ch == CH_LE) || (in_ch == CH_UE);
  assign ph_int   = (phase_r == P_INT) || ((phase_r == P_SIGN) && (in_ch != CH_MINUS));
  assign ph_expd  = (phase_r == P_EXPDIG) ||
                    ((phase_r == P_EXPSIGN) && (in_ch != CH_PLUS) && (in_ch != CH_MINUS));
  assign expd_v   = {4'b0000, expd_r} * (EW+4)'(10) + (EW+4)'(dval);
  assign esum     = {1'b0, frac_r} + {1'b0, expd_r};
  // scaling leaves zero and infinity unchanged
  assign acc_done = (accum_r[62:0] == 63'd0) || (&accum_r[62:52]);

  always_comb begin
    phase_nxt     = phase_r;
    state_nxt     = state_r;
    accum_nxt     = accum_r;
    frac_nxt      = frac_r;
    expd_nxt      = expd_r;
    exp_neg_nxt   = exp_neg_r;
    is_neg_nxt    = is_neg_r;
    scale_nxt     = scale_r;
    scale_neg_nxt = scale_neg_r;
    emit_neg_nxt  = emit_neg_r;
    digit_nxt     = digit_r;
    wait_nxt      = wait_r;
    cmd_nxt       = '{start: 1'b0, op: OP_MUL10};
    out_valid_nxt = out_valid_r && !out_ready;
    out_bits_nxt  = out_bits_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if ((phase_r == P_SIGN) && (in_ch == CH_MINUS)) begin
            is_neg_nxt = 1'b1;
            phase_nxt  = P_INT;
          end else if (phase_r == P_SKIP) begin
            if (in_ch == CH_NUL) phase_nxt = P_SIGN;
          end else if ((phase_r == P_EXPSIGN) && (in_ch == CH_PLUS)) begin
            phase_nxt = P_EXPDIG;
          end else if ((phase_r == P_EXPSIGN) && (in_ch == CH_MINUS)) begin
            exp_neg_nxt = 1'b1;
            phase_nxt   = P_EXPDIG;
          end else if (ph_expd && is_dig) begin
            expd_nxt  = (expd_v > (EW+4)'(BOUND)) ? BOUND : expd_v[EW-1:0];
            phase_nxt = P_EXPDIG;
          end else if ((ph_int || (phase_r == P_FRAC)) && is_dig) begin
            // mantissa digit: accum * 10.0, then + digit
            digit_nxt = dval;
            cmd_nxt   = '{start: 1'b1, op: OP_MUL10};
            state_nxt = S_MUL10;
            if (phase_r == P_FRAC) begin
              if (frac_r < BOUND) frac_nxt = frac_r + EW'(1);
            end else begin
              phase_nxt = P_INT;
            end
          end else if (ph_int && (in_ch == CH_DOT)) begin
            phase_nxt = P_FRAC;
          end else if ((ph_int || (phase_r == P_FRAC)) && is_e) begin
            phase_nxt = P_EXPSIGN;
          end else begin
            // end of number: fix the clamped exponent, clear the parse state
            if (exp_neg_r) begin
              scale_neg_nxt = 1'b1;
              scale_nxt     = (esum > {1'b0, BOUND}) ? BOUND : esum[EW-1:0];
            end else if (expd_r >= frac_r) begin
              scale_neg_nxt = 1'b0;
              scale_nxt     = expd_r - frac_r;
            end else begin
              scale_neg_nxt = 1'b1;
              scale_nxt     = frac_r - expd_r;
            end
            emit_neg_nxt = is_neg_r;
            is_neg_nxt   = 1'b0;
            exp_neg_nxt  = 1'b0;
            frac_nxt     = '0;
            expd_nxt     = '0;
            phase_nxt    = (in_ch == CH_NUL) ? P_SIGN : P_SKIP;
            wait_nxt     = 1'b0;
            state_nxt    = S_SCALE;
          end
        end
      end
      S_MUL10: begin
        if (fpu_stat.done) begin
          accum_nxt = fpu_res;
          cmd_nxt   = '{start: 1'b1, op: OP_ADD};
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        if (fpu_stat.done) begin
          accum_nxt = fpu_res;
          state_nxt = S_IDLE;
        end
      end
      S_SCALE: begin
        // one multiply by 10.0 or 0.1 per unit of exponent
        if (wait_r) begin
          if (fpu_stat.done) begin
            accum_nxt = fpu_res;
            wait_nxt  = 1'b0;
          end
        end else if ((scale_r == '0) || acc_done) begin
          state_nxt = S_EMIT;
        end else begin
          cmd_nxt   = '{start: 1'b1, op: (scale_neg_r ? OP_MUL01 : OP_MUL10)};
          scale_nxt = scale_r - EW'(1);
          wait_nxt  = 1'b1;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_bits_nxt  = {accum_r[63] ^ emit_neg_r, accum_r[62:0]};
          accum_nxt     = DBL_POS_ZERO;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= P_SIGN;
      state_r     <= S_IDLE;
      accum_r     <= DBL_POS_ZERO;
      frac_r      <= '0;
      expd_r      <= '0;
      exp_neg_r   <= 1'b0;
      is_neg_r    <= 1'b0;
      wait_r      <= 1'b0;
      cmd_r       <= '{start: 1'b0, op: OP_MUL10};
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      state_r     <= state_nxt;
      accum_r     <= accum_nxt;
      frac_r      <= frac_nxt;
      expd_r      <= expd_nxt;
      exp_neg_r   <= exp_neg_nxt;
      is_neg_r    <= is_neg_nxt;
      wait_r      <= wait_nxt;
      cmd_r       <= cmd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scale_r     <= scale_nxt;
    scale_neg_r <= scale_neg_nxt;
    emit_neg_r  <= emit_neg_nxt;
    digit_r     <= digit_nxt;
    out_bits_r  <= out_bits_nxt;
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_value_bits = out_bits_r;

  // FPU results only arrive while the sequencer waits for one
  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    fpu_stat.done |-> ((state_r == S_MUL10) || (state_r == S_ADD) ||
                       ((state_r == S_SCALE) && wait_r)))
    else $error("fpu result with no operation outstanding");

  // a new operation never hits a busy unit
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_r.start |-> !fpu_stat.busy)
    else $error("fpu started while busy");

  // loading the result register returns to idle with an item on offer
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EMIT) && (!out_valid_r || out_ready)) |=> (out_valid && in_ready))
    else $error("result not loaded on emit");

  // a dropped character leaves the input ready for the next one
  a_skip_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (phase_r == P_SKIP)) |=> in_ready)
    else $error("skip stalled the input");

endmodule
